// File: rtl/core/tcs_pkg.sv
// Shared types, command codes and helpers for the triangle contour segment unit.
// No dependencies.
package tcs_pkg;

  localparam int unsigned FIELD_W   = 32;
  localparam int unsigned IN_DATA_W  = 288;
  localparam int unsigned OUT_DATA_W = 224;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ISO     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPACING = 2'd2;

  localparam logic [1:0] EDGE_01 = 2'd0;
  localparam logic [1:0] EDGE_12 = 2'd1;
  localparam logic [1:0] EDGE_20 = 2'd2;

  localparam logic [3:0] OP_NONE     = 4'd0;
  localparam logic [3:0] OP_LOAD     = 4'd1;
  localparam logic [3:0] OP_RANGE    = 4'd2;
  localparam logic [3:0] OP_SETUP    = 4'd3;
  localparam logic [3:0] OP_DIV_LO   = 4'd4;
  localparam logic [3:0] OP_K0       = 4'd5;
  localparam logic [3:0] OP_DIV_HI   = 4'd6;
  localparam logic [3:0] OP_KEND     = 4'd7;
  localparam logic [3:0] OP_LVL      = 4'd8;
  localparam logic [3:0] OP_EDGE_DIV = 4'd9;
  localparam logic [3:0] OP_T        = 4'd10;
  localparam logic [3:0] OP_MULX     = 4'd11;
  localparam logic [3:0] OP_PTX_MULY = 4'd12;
  localparam logic [3:0] OP_PTY      = 4'd13;
  localparam logic [3:0] OP_EMIT     = 4'd14;

  typedef struct packed {
    logic [3:0] op;
    logic       slot;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic mode;
    logic levels_done;
    logic out_free;
  } stat_t;

  function automatic logic [FIELD_W-1:0] sat_field(input logic signed [49:0] v,
                                                    input int unsigned cw);
    logic signed [49:0] hi;
    logic signed [49:0] lo;
    logic signed [49:0] r;
    hi = (50'sd1 <<< (cw - 1)) - 50'sd1;
    lo = -hi - 50'sd1;
    if (v > hi) r = hi;
    else if (v < lo) r = lo;
    else r = v;
    return r[FIELD_W-1:0];
  endfunction

endpackage

// File: rtl/core/tcs_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, 64-bit dividend.
// Depends on nothing.
module tcs_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [63:0] quot,
  output logic [31:0] rem
);
  logic [31:0] dvs;
  logic [6:0]  count;
  logic [32:0] trial;
  logic        fits;

  assign trial = {rem, quot[63]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= 7'd0;
      quot  <= dividend;
      rem   <= '0;
      dvs   <= divisor;
    end else if (busy) begin
      rem   <= fits ? 32'(trial - {1'b0, dvs}) : trial[31:0];
      quot  <= {quot[62:0], fits};
      count <= count + 7'd1;
      if (count == 7'd63) busy <= 1'b0;
    end
  end
endmodule

// File: rtl/core/tcs_datapath.sv
// Datapath: config registers, triangle registers, level setup, edge interpolation,
// output register. Depends on tcs_pkg and tcs_div.
module tcs_datapath #(
  parameter int unsigned MAX_LEVELS = 16,
  parameter int unsigned COORD_W    = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  tcs_pkg::cmd_t                     cmd,
  output tcs_pkg::stat_t                    stat,
  input  logic                              cfg_we,
  input  logic [tcs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                       cfg_data,
  input  logic [tcs_pkg::IN_DATA_W-1:0]     s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [tcs_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic                              m_tlast,
  output logic [0:0]                        m_tuser
);
  import tcs_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_LEVELS + 1);

  logic               mode;
  logic signed [31:0] iso;
  logic [30:0]        spacing;
  logic [30:0]        s_eff;

  logic signed [31:0] ax, ay, ah, bx, by, bh, cx, cy, ch;
  logic signed [31:0] hmin, hmax, hmin_next, hmax_next;
  logic signed [33:0] k, lvl, kend;
  logic [CNT_W-1:0]   cnt, total;
  logic               dropped;
  logic [1:0]         edge_q, edge_sel, edge_use;
  logic [31:0]        t;
  logic [63:0]        prod;
  logic               neg;
  logic [31:0]        px, py, qx, qy;

  logic               div_start, div_busy;
  logic [63:0]        dvd, quot;
  logic [31:0]        dvs, rem;

  logic               above0, above1, above2, c0, c2;
  logic signed [31:0] ha, hb, xa, xb, ya, yb;
  logic signed [34:0] ndiff;
  logic signed [32:0] ddiff, dx, dy;
  logic [31:0]        n32, d32, magx, magy;
  logic signed [33:0] diff;
  logic [63:0]        rnd;
  logic signed [49:0] base_c, pt_val;
  logic [31:0]        pt_sat;
  logic signed [65:0] lvl_prod;

  assign s_eff = (spacing == 31'd0) ? 31'd1 : spacing;

  function automatic logic signed [33:0] ceil_q(input logic neg_a, input logic [31:0] q,
                                                  input logic [31:0] r);
    logic signed [33:0] v;
    v = $signed({2'b00, q});
    if (neg_a) return -v;
    return v + ((r != 32'd0) ? 34'sd1 : 34'sd0);
  endfunction

  always_comb begin
    hmin_next = ah;
    hmax_next = ah;
    if (bh < hmin_next) hmin_next = bh;
    if (ch < hmin_next) hmin_next = ch;
    if (bh > hmax_next) hmax_next = bh;
    if (ch > hmax_next) hmax_next = ch;
  end

  assign above0 = 34'(ah) > lvl;
  assign above1 = 34'(bh) > lvl;
  assign above2 = 34'(ch) > lvl;
  assign c0 = above0 != above1;
  assign c2 = above2 != above0;
  assign edge_sel = cmd.slot ? (c2 ? EDGE_20 : EDGE_12) : (c0 ? EDGE_01 : EDGE_12);
  assign edge_use = (cmd.op == OP_EDGE_DIV) ? edge_sel : edge_q;

  always_comb begin
    unique case (edge_use)
      EDGE_01: begin ha = ah; hb = bh; xa = ax; xb = bx; ya = ay; yb = by; end
      EDGE_12: begin ha = bh; hb = ch; xa = bx; xb = cx; ya = by; yb = cy; end
      default: begin ha = ch; hb = ah; xa = cx; xb = ax; ya = cy; yb = ay; end
    endcase
  end

  assign ndiff = 35'(lvl) - 35'(ha);
  assign n32   = ndiff[34] ? 32'(-ndiff) : ndiff[31:0];
  assign ddiff = 33'(hb) - 33'(ha);
  assign d32   = ddiff[32] ? 32'(-ddiff) : ddiff[31:0];
  assign dx    = 33'(xb) - 33'(xa);
  assign dy    = 33'(yb) - 33'(ya);
  assign magx  = dx[32] ? 32'(-dx) : dx[31:0];
  assign magy  = dy[32] ? 32'(-dy) : dy[31:0];

  always_comb begin
    div_start = 1'b0;
    dvd = '0;
    dvs = {1'b0, s_eff};
    unique case (cmd.op)
      OP_DIV_LO: begin
        div_start = 1'b1;
        dvd = {32'd0, hmin[31] ? 32'(-hmin) : hmin};
      end
      OP_DIV_HI: begin
        div_start = 1'b1;
        dvd = {32'd0, hmax[31] ? 32'(-hmax) : hmax};
      end
      OP_EDGE_DIV: begin
        div_start = 1'b1;
        dvd = {1'b0, n32, 31'd0};
        dvs = d32;
      end
      default: ;
    endcase
  end

  tcs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .busy     (div_busy),
    .quot     (quot),
    .rem      (rem)
  );

  assign kend     = ceil_q(hmax[31], quot[31:0], rem);
  assign diff     = kend - k;
  assign lvl_prod = 66'(k) * $signed({35'd0, s_eff});
  assign rnd      = prod + 64'h4000_0000;
  assign base_c   = (cmd.op == OP_PTY) ? 50'(ya) : 50'(xa);
  assign pt_val   = neg ? base_c - $signed({17'd0, rnd[63:31]})
                        : base_c + $signed({17'd0, rnd[63:31]});
  assign pt_sat   = sat_field(pt_val, COORD_W);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= 1'b0;
      iso     <= '0;
      spacing <= 31'd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:    mode    <= cfg_data[0];
        REG_ISO:     iso     <= cfg_data;
        REG_SPACING: spacing <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        ax <= s_tdata[31:0];    ay <= s_tdata[63:32];   ah <= s_tdata[95:64];
        bx <= s_tdata[127:96];  by <= s_tdata[159:128]; bh <= s_tdata[191:160];
        cx <= s_tdata[223:192]; cy <= s_tdata[255:224]; ch <= s_tdata[287:256];
      end
      OP_RANGE: begin
        hmin <= hmin_next;
        hmax <= hmax_next;
      end
      OP_SETUP: begin
        k       <= '0;
        lvl     <= 34'(iso);
        cnt     <= '0;
        dropped <= 1'b0;
        total   <= (hmin <= iso && iso < hmax) ? CNT_W'(1) : '0;
      end
      OP_K0: k <= ceil_q(hmin[31], quot[31:0], rem);
      OP_KEND: begin
        cnt <= '0;
        if (diff > 34'(MAX_LEVELS)) begin
          total   <= CNT_W'(MAX_LEVELS);
          dropped <= 1'b1;
        end else begin
          total   <= diff[CNT_W-1:0];
          dropped <= 1'b0;
        end
      end
      OP_LVL:      lvl    <= lvl_prod[33:0];
      OP_EDGE_DIV: edge_q <= edge_sel;
      OP_T:        t      <= quot[31:0];
      OP_MULX: begin
        prod <= 64'(magx) * 64'(t);
        neg  <= dx[32];
      end
      OP_PTX_MULY: begin
        if (cmd.slot) qx <= pt_sat;
        else px <= pt_sat;
        prod <= 64'(magy) * 64'(t);
        neg  <= dy[32];
      end
      OP_PTY: begin
        if (cmd.slot) qy <= pt_sat;
        else py <= pt_sat;
      end
      OP_EMIT: begin
        m_tdata <= {sat_field(50'(lvl), COORD_W), qy, qx,
                    sat_field(50'(lvl), COORD_W), py, px, k[31:0]};
        m_tlast    <= (cnt + CNT_W'(1)) == total;
        m_tuser[0] <= dropped;
        k   <= k + 34'sd1;
        lvl <= lvl + $signed({3'd0, s_eff});
        cnt <= cnt + CNT_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (cmd.op == OP_EMIT) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  assign stat.div_busy    = div_busy;
  assign stat.mode        = mode;
  assign stat.levels_done = cnt == total;
  assign stat.out_free    = !m_tvalid;
endmodule

// File: rtl/core/tcs_ctrl.sv
// Controller state machine sequencing level setup and per-level edge interpolation.
// Depends on tcs_pkg.
module tcs_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  tcs_pkg::stat_t stat,
  output tcs_pkg::cmd_t  cmd
);
  import tcs_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_RANGE = 4'd1;
  localparam logic [3:0] ST_SETUP = 4'd2;
  localparam logic [3:0] ST_DLO   = 4'd3;
  localparam logic [3:0] ST_WLO   = 4'd4;
  localparam logic [3:0] ST_DHI   = 4'd5;
  localparam logic [3:0] ST_WHI   = 4'd6;
  localparam logic [3:0] ST_MLVL  = 4'd7;
  localparam logic [3:0] ST_LEVEL = 4'd8;
  localparam logic [3:0] ST_EDIV  = 4'd9;
  localparam logic [3:0] ST_EWAIT = 4'd10;
  localparam logic [3:0] ST_MULX  = 4'd11;
  localparam logic [3:0] ST_PTX   = 4'd12;
  localparam logic [3:0] ST_PTY   = 4'd13;
  localparam logic [3:0] ST_EMIT  = 4'd14;

  logic [3:0] state, state_next;
  logic       slot, slot_next;

  always_comb begin
    state_next = state;
    slot_next  = slot;
    cmd.op     = OP_NONE;
    cmd.slot   = slot;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.op = OP_LOAD;
          state_next = ST_RANGE;
        end
      end
      ST_RANGE: begin
        cmd.op = OP_RANGE;
        state_next = stat.mode ? ST_DLO : ST_SETUP;
      end
      ST_SETUP: begin
        cmd.op = OP_SETUP;
        state_next = ST_LEVEL;
      end
      ST_DLO: begin
        cmd.op = OP_DIV_LO;
        state_next = ST_WLO;
      end
      ST_WLO: if (!stat.div_busy) begin
        cmd.op = OP_K0;
        state_next = ST_DHI;
      end
      ST_DHI: begin
        cmd.op = OP_DIV_HI;
        state_next = ST_WHI;
      end
      ST_WHI: if (!stat.div_busy) begin
        cmd.op = OP_KEND;
        state_next = ST_MLVL;
      end
      ST_MLVL: begin
        cmd.op = OP_LVL;
        state_next = ST_LEVEL;
      end
      ST_LEVEL: begin
        slot_next  = 1'b0;
        state_next = stat.levels_done ? ST_IDLE : ST_EDIV;
      end
      ST_EDIV: begin
        cmd.op = OP_EDGE_DIV;
        state_next = ST_EWAIT;
      end
      ST_EWAIT: if (!stat.div_busy) begin
        cmd.op = OP_T;
        state_next = ST_MULX;
      end
      ST_MULX: begin
        cmd.op = OP_MULX;
        state_next = ST_PTX;
      end
      ST_PTX: begin
        cmd.op = OP_PTX_MULY;
        state_next = ST_PTY;
      end
      ST_PTY: begin
        cmd.op = OP_PTY;
        if (slot) state_next = ST_EMIT;
        else begin
          slot_next  = 1'b1;
          state_next = ST_EDIV;
        end
      end
      ST_EMIT: if (stat.out_free) begin
        cmd.op = OP_EMIT;
        state_next = ST_LEVEL;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      slot  <= 1'b0;
    end else begin
      state <= state_next;
      slot  <= slot_next;
    end
  end
endmodule

// File: rtl/core/triangle_contour_segments_unit.sv
// Top level of the triangle contour segment unit: controller plus datapath.
// Depends on tcs_pkg, tcs_ctrl, tcs_datapath.
//
// channel  direction  contents
// s_*      in         one triangle: three vertices (x, y, height), Q16.16
// m_*      out        one contour segment per crossing level
// cfg_*    in         register writes: level_mode, iso_height, level_spacing
//
// Spaced mode: level setup per triangle uses two 64-step divisions; each
// segment costs two 64-step divisions through the one shared divider.
// Reset is synchronous; the output register holds a segment until taken and
// stalls the sequencer only when a new one is ready.
module triangle_contour_segments_unit #(
  parameter int unsigned MAX_LEVELS_PER_TRIANGLE = 16,
  parameter int unsigned COORD_WIDTH             = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // ax_in, ay_in, ah_in, bx_in, by_in, bh_in, cx_in, cy_in, ch_in
  input  logic [tcs_pkg::IN_DATA_W-1:0]     s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // level_index, p_x, p_y, p_h, q_x, q_y, q_h
  output logic [tcs_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic                              m_tlast,
  // levels_dropped
  output logic [0:0]                        m_tuser,
  input  logic                              cfg_we,
  input  logic [tcs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                       cfg_data
);
  import tcs_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  tcs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tcs_datapath #(
    .MAX_LEVELS (MAX_LEVELS_PER_TRIANGLE),
    .COORD_W    (COORD_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );
endmodule
